[sv/fpd_pkg.sv]
package fpd_pkg;

    // Field and register widths
    localparam int ALT_W    = 21;
    localparam int TIME_W   = 32;
    localparam int SPD_W    = 15;
    localparam int STILL_W  = 14;
    localparam int WIN_W    = 17;
    localparam int HGT_W    = 20;
    localparam int AVG_W    = 24;
    localparam int VZ_W     = 16;
    localparam int ADDR_W   = 5;

    // Smoothing and dwell constants
    localparam int ALPHA_Q8          = 64;
    localparam int DWELL_CLIMB_MS    = 2000;
    localparam int DWELL_GROUND_MS   = 5000;
    localparam int DWELL_FREEFALL_MS = 2000;
    localparam int DWELL_CANOPY_MS   = 2000;

    localparam int SPEED_LIMIT   = 32767;
    localparam int DEADBAND_CM_S = 5;
    localparam int VZ_SCALE      = 1000;

    // Divider: numerator magnitude is at most 2^21 * 1000, below 2^31
    localparam int NUM_W = 31;
    localparam int CNT_W = 5;

    // Flight modes
    localparam logic [1:0] MODE_GROUND   = 2'd0;
    localparam logic [1:0] MODE_CLIMB    = 2'd1;
    localparam logic [1:0] MODE_FREEFALL = 2'd2;
    localparam logic [1:0] MODE_CANOPY   = 2'd3;

    // Register indexes
    localparam logic [2:0] REG_GROUND_BASE  = 3'd0;
    localparam logic [2:0] REG_CLIMB_ENTER  = 3'd1;
    localparam logic [2:0] REG_STILL        = 3'd2;
    localparam logic [2:0] REG_FF_ENTER     = 3'd3;
    localparam logic [2:0] REG_CANOPY_ENTER = 3'd4;
    localparam logic [2:0] REG_CANOPY_EXIT  = 3'd5;
    localparam logic [2:0] REG_GROUND_WIN   = 3'd6;
    localparam logic [2:0] REG_CANOPY_MIN   = 3'd7;

endpackage

[sv/flight_phase_detector.sv]
// Flight phase detector. Each input transaction is an altitude sample (cm) with a
// millisecond timestamp; each produces exactly one output transaction carrying the
// flight mode (ground, climb, freefall, canopy) and the Q8 smoothed vertical speed.
// A sample with a nonzero time step is loaded in its acceptance cycle, then passes the
// bit-serial restoring divider that forms the raw speed, then saturate, average,
// mode-update and output steps. A zero time step skips the divider, and the first
// sample after reset or after a zero timestamp only stores the sample. in_stall is
// high while a sample is in work and while a finished result waits for the output
// register. Thresholds are written through the APB port at byte address 4*index and
// should only change while idle.
module flight_phase_detector
    import fpd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // sample input
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [ALT_W-1:0]  altitude_cm,
    input  logic [TIME_W-1:0]        time_ms,
    // result output
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               mode,
    output logic signed [AVG_W-1:0]  smoothed_speed_q8,
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_W-1:0]        paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_SPEED = 3'd2;
    localparam logic [2:0] S_AVG   = 3'd3;
    localparam logic [2:0] S_FSM   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // Configuration registers
    logic signed [ALT_W-1:0]   ground_base_reg;
    logic signed [SPD_W-1:0]   climb_enter_reg;
    logic [STILL_W-1:0]        still_speed_reg;
    logic signed [SPD_W-1:0]   ff_enter_reg;
    logic signed [SPD_W-1:0]   canopy_enter_reg;
    logic signed [SPD_W-1:0]   canopy_exit_reg;
    logic [WIN_W-1:0]          ground_win_reg;
    logic [HGT_W-1:0]          canopy_min_reg;

    // Detector state
    logic [2:0]                state_reg, state_next;
    logic signed [ALT_W-1:0]   last_alt_reg, last_alt_next;
    logic [TIME_W-1:0]         last_time_reg, last_time_next;
    logic [TIME_W-1:0]         entry_time_reg, entry_time_next;
    logic [1:0]                mode_reg, mode_next;
    logic signed [AVG_W-1:0]   avg_reg, avg_next;
    logic [TIME_W-1:0]         hold_reg, hold_next;

    // Per-sample working registers
    logic signed [ALT_W-1:0]   alt_reg, alt_next;
    logic [TIME_W-1:0]         now_reg, now_next;
    logic [TIME_W-1:0]         dt_reg, dt_next;
    logic                      neg_reg, neg_next;
    logic [TIME_W-1:0]         rem_reg, rem_next;
    logic [NUM_W-1:0]          quo_reg, quo_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [VZ_W-1:0]    vz_reg, vz_next;

    // Output register
    logic                      out_valid_reg, out_valid_next;
    logic [1:0]                out_mode_reg, out_mode_next;
    logic signed [AVG_W-1:0]   out_avg_reg, out_avg_next;

    logic                      cfg_wr;
    logic [2:0]                cfg_idx;
    logic                      in_acc;

    // Load-cycle arithmetic
    logic signed [ALT_W:0]     dalt;
    logic [ALT_W:0]            dalt_mag;
    logic [31:0]               num_full;
    logic [TIME_W-1:0]         dt_in;

    // Shared divider step
    logic [TIME_W:0]           trial;
    logic                      fits;

    // Speed saturation
    logic [NUM_W-1:0]          q_sat;
    logic [VZ_W-1:0]           q_mag;

    // Averaging
    logic signed [33:0]        keep_prod;
    logic signed [33:0]        alpha_prod;
    logic signed [33:0]        avg_sum;

    // Mode decision terms
    logic signed [ALT_W:0]     height;
    logic [ALT_W:0]            height_mag;
    logic [AVG_W-1:0]          avg_mag;
    logic                      still, near;
    logic                      above_climb, below_ff, above_canopy, below_exit;
    logic                      high_enough;
    logic [TIME_W-1:0]         elapsed;
    logic [TIME_W-1:0]         hold_start;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign cfg_idx  = paddr[ADDR_W-1:2];
    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid & ~in_stall;

    assign out_valid         = out_valid_reg;
    assign mode              = out_mode_reg;
    assign smoothed_speed_q8 = out_avg_reg;

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ground_base_reg  <= '0;
            climb_enter_reg  <= SPD_W'(100);
            still_speed_reg  <= STILL_W'(50);
            ff_enter_reg     <= SPD_W'(-1500);
            canopy_enter_reg <= SPD_W'(-1200);
            canopy_exit_reg  <= SPD_W'(-2500);
            ground_win_reg   <= WIN_W'(3000);
            canopy_min_reg   <= HGT_W'(30000);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_GROUND_BASE:  ground_base_reg  <= pwdata[ALT_W-1:0];
                REG_CLIMB_ENTER:  climb_enter_reg  <= pwdata[SPD_W-1:0];
                REG_STILL:        still_speed_reg  <= pwdata[STILL_W-1:0];
                REG_FF_ENTER:     ff_enter_reg     <= pwdata[SPD_W-1:0];
                REG_CANOPY_ENTER: canopy_enter_reg <= pwdata[SPD_W-1:0];
                REG_CANOPY_EXIT:  canopy_exit_reg  <= pwdata[SPD_W-1:0];
                REG_GROUND_WIN:   ground_win_reg   <= pwdata[WIN_W-1:0];
                REG_CANOPY_MIN:   canopy_min_reg   <= pwdata[HGT_W-1:0];
                default: ;
            endcase
        end
    end

    // Configuration read
    always_comb
    begin
        unique case (cfg_idx)
            REG_GROUND_BASE:  prdata = 32'(ground_base_reg);
            REG_CLIMB_ENTER:  prdata = 32'(climb_enter_reg);
            REG_STILL:        prdata = 32'(still_speed_reg);
            REG_FF_ENTER:     prdata = 32'(ff_enter_reg);
            REG_CANOPY_ENTER: prdata = 32'(canopy_enter_reg);
            REG_CANOPY_EXIT:  prdata = 32'(canopy_exit_reg);
            REG_GROUND_WIN:   prdata = 32'(ground_win_reg);
            REG_CANOPY_MIN:   prdata = 32'(canopy_min_reg);
            default:          prdata = '0;
        endcase
    end

    // Numerator magnitude and time step at load
    assign dalt     = (ALT_W+1)'(altitude_cm) - (ALT_W+1)'(last_alt_reg);
    assign dalt_mag = dalt[ALT_W] ? (ALT_W+1)'(-dalt) : (ALT_W+1)'(dalt);
    assign num_full = 32'(dalt_mag) * 32'(VZ_SCALE);
    assign dt_in    = time_ms - last_time_reg;

    // Restoring divider step
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign fits  = (trial >= {1'b0, dt_reg});

    // Saturate, then dead band
    assign q_sat = (quo_reg > NUM_W'(SPEED_LIMIT)) ? NUM_W'(SPEED_LIMIT) : quo_reg;
    assign q_mag = (q_sat < NUM_W'(DEADBAND_CM_S)) ? '0 : q_sat[VZ_W-1:0];

    // Q8 exponential average, floor of the kept part
    assign keep_prod  = 34'(avg_reg) * $signed(34'(256 - ALPHA_Q8));
    assign alpha_prod = 34'(vz_reg) * $signed(34'(ALPHA_Q8));
    assign avg_sum    = alpha_prod + (keep_prod >>> 8);

    // Mode decision terms, against the updated average
    assign height       = (ALT_W+1)'(alt_reg) - (ALT_W+1)'(ground_base_reg);
    assign height_mag   = height[ALT_W] ? (ALT_W+1)'(-height) : (ALT_W+1)'(height);
    assign avg_mag      = avg_reg[AVG_W-1] ? AVG_W'(-avg_reg) : AVG_W'(avg_reg);
    assign still        = (avg_mag < AVG_W'({still_speed_reg, 8'b0}));
    assign near         = (height_mag < (ALT_W+1)'(ground_win_reg));
    assign above_climb  = (avg_reg > $signed({climb_enter_reg[SPD_W-1], climb_enter_reg, 8'b0}));
    assign below_ff     = (avg_reg < $signed({ff_enter_reg[SPD_W-1], ff_enter_reg, 8'b0}));
    assign above_canopy = (avg_reg > $signed({canopy_enter_reg[SPD_W-1], canopy_enter_reg,
                                              8'b0}));
    assign below_exit   = (avg_reg < $signed({canopy_exit_reg[SPD_W-1], canopy_exit_reg,
                                              8'b0}));
    assign high_enough  = (height > $signed((ALT_W+1)'(canopy_min_reg)));
    assign elapsed      = now_reg - entry_time_reg;
    assign hold_start   = (hold_reg == '0) ? now_reg : hold_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        last_alt_next   = last_alt_reg;
        last_time_next  = last_time_reg;
        entry_time_next = entry_time_reg;
        mode_next       = mode_reg;
        avg_next        = avg_reg;
        hold_next       = hold_reg;
        alt_next        = alt_reg;
        now_next        = now_reg;
        dt_next         = dt_reg;
        neg_next        = neg_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        cnt_next        = cnt_reg;
        vz_next         = vz_reg;
        out_valid_next  = out_valid_reg & out_stall;
        out_mode_next   = out_mode_reg;
        out_avg_next    = out_avg_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    alt_next = altitude_cm;
                    now_next = time_ms;
                    dt_next  = dt_in;
                    neg_next = dalt[ALT_W];
                    rem_next = '0;
                    quo_next = num_full[NUM_W-1:0];
                    cnt_next = CNT_W'(NUM_W - 1);
                    if (last_time_reg == '0)
                    begin
                        // first sample only stores
                        last_alt_next   = altitude_cm;
                        last_time_next  = time_ms;
                        entry_time_next = time_ms;
                        state_next      = S_DONE;
                    end
                    else if (dt_in == '0)
                    begin
                        vz_next    = '0;
                        state_next = S_AVG;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                rem_next = fits ? TIME_W'(trial - {1'b0, dt_reg}) : trial[TIME_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], fits};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_SPEED;
                end
            end
            S_SPEED:
            begin
                vz_next    = neg_reg ? VZ_W'(-q_mag) : VZ_W'(q_mag);
                state_next = S_AVG;
            end
            S_AVG:
            begin
                avg_next   = avg_sum[AVG_W-1:0];
                state_next = S_FSM;
            end
            S_FSM:
            begin
                unique case (mode_reg)
                    MODE_GROUND:
                    begin
                        if (above_climb && elapsed >= TIME_W'(DWELL_CLIMB_MS))
                        begin
                            mode_next       = MODE_CLIMB;
                            entry_time_next = now_reg;
                        end
                    end
                    MODE_CLIMB:
                    begin
                        // hold near ground before returning, else try freefall
                        if (still && near &&
                            (now_reg - hold_start) >= TIME_W'(DWELL_GROUND_MS))
                        begin
                            mode_next       = MODE_GROUND;
                            entry_time_next = now_reg;
                            hold_next       = '0;
                        end
                        else
                        begin
                            hold_next = (still && near) ? hold_start : '0;
                            if (below_ff && elapsed >= TIME_W'(DWELL_CLIMB_MS))
                            begin
                                mode_next       = MODE_FREEFALL;
                                entry_time_next = now_reg;
                            end
                        end
                    end
                    MODE_FREEFALL:
                    begin
                        if (above_canopy && high_enough &&
                            elapsed >= TIME_W'(DWELL_FREEFALL_MS))
                        begin
                            mode_next       = MODE_CANOPY;
                            entry_time_next = now_reg;
                        end
                    end
                    MODE_CANOPY:
                    begin
                        priority if (below_exit && elapsed >= TIME_W'(DWELL_CANOPY_MS))
                        begin
                            mode_next       = MODE_FREEFALL;
                            entry_time_next = now_reg;
                        end
                        else if (still && near && elapsed >= TIME_W'(DWELL_GROUND_MS))
                        begin
                            mode_next       = MODE_GROUND;
                            entry_time_next = now_reg;
                        end
                    end
                    default: ;
                endcase
                last_alt_next  = alt_reg;
                last_time_next = now_reg;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_mode_next  = mode_reg;
                    out_avg_next   = avg_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and detector state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            last_alt_reg   <= '0;
            last_time_reg  <= '0;
            entry_time_reg <= '0;
            mode_reg       <= MODE_GROUND;
            avg_reg        <= '0;
            hold_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            last_alt_reg   <= last_alt_next;
            last_time_reg  <= last_time_next;
            entry_time_reg <= entry_time_next;
            mode_reg       <= mode_next;
            avg_reg        <= avg_next;
            hold_reg       <= hold_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        alt_reg      <= alt_next;
        now_reg      <= now_next;
        dt_reg       <= dt_next;
        neg_reg      <= neg_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        vz_reg       <= vz_next;
        out_mode_reg <= out_mode_next;
        out_avg_reg  <= out_avg_next;
    end

    // Checks
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done step");

    a_mode_only_in_fsm: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_FSM) |=> $stable(mode_reg))
        else $error("mode changed outside the mode update step");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (rem_reg < dt_reg))
        else $error("divider remainder not below divisor");

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == S_DIV || state_reg == S_AVG || state_reg == S_DONE))
        else $error("bad step after accepting a transaction");

    a_avg_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (avg_reg <= $signed(AVG_W'(SPEED_LIMIT * 256))) &&
        (avg_reg >= $signed(AVG_W'(-SPEED_LIMIT * 256))))
        else $error("smoothed speed out of range");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
    import fpd_pkg::*;

    // Behavior constants kept apart from the design's own copies
    localparam longint SMOOTH_ALPHA   = 64;
    localparam longint SPEED_SAT      = 32767;
    localparam longint DEADBAND       = 5;
    localparam logic [31:0] CLIMB_DWELL  = 32'd2000;
    localparam logic [31:0] GROUND_DWELL = 32'd5000;
    localparam logic [31:0] FALL_DWELL   = 32'd2000;
    localparam logic [31:0] CANOPY_DWELL = 32'd2000;
    localparam longint ALT_MAX = 1048575;
    localparam longint ALT_MIN = -1048576;

    localparam int RANDOM_ITEMS = 600;
    localparam int QUIET_ITEMS  = 150;
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct packed {
        logic [1:0]       mode;
        logic [AVG_W-1:0] speed;
    } phase_t;

    // DUT signals
    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic signed [ALT_W-1:0] altitude_cm = '0;
    logic [TIME_W-1:0]       time_ms = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [1:0]              mode;
    logic signed [AVG_W-1:0] smoothed_speed_q8;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [ADDR_W-1:0]       paddr = '0;
    logic [31:0]             pwdata = '0;
    logic [31:0]             prdata;
    logic                    pready;

    // Register shadows (reset values)
    longint base_cm     = 0;
    longint climb_thr   = 100;
    longint still_thr   = 50;
    longint ff_thr      = -1500;
    longint can_in_thr  = -1200;
    longint can_out_thr = -2500;
    longint win_cm      = 3000;
    longint can_min_cm  = 30000;

    // Predicted block state
    longint      prev_alt = 0;
    logic [31:0] prev_ms  = '0;
    logic [31:0] entry_ms = '0;
    logic [31:0] hold_ms  = '0;
    logic [1:0]  cur_mode = MODE_GROUND;
    longint      avg_q8   = 0;

    phase_t expected_phases[$];
    phase_t want;

    // Stimulus bookkeeping
    longint      sim_alt = 0;
    logic [31:0] sim_ms  = '0;
    bit          in_gaps_on = 1'b1;
    bit          out_stalls_on = 1'b1;
    int          samples_sent = 0;
    int          results_checked = 0;
    int          fail_count = 0;
    int          settings_written = 0;
    int          flights = 0;
    int          hops = 0;
    int          cycle_count = 0;
    int          mode_hits [4] = '{0, 0, 0, 0};

    flight_phase_detector i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .altitude_cm       (altitude_cm),
        .time_ms           (time_ms),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .mode              (mode),
        .smoothed_speed_q8 (smoothed_speed_q8),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // Clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Random output back-pressure
    always @(posedge clk)
    begin
        out_stall <= out_stalls_on && ($urandom_range(99) < 11);
    end

    // Result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_phases.size() == 0)
            begin
                $display("%0t unexpected result: mode %0d speed %0d", $time, mode,
                         smoothed_speed_q8);
                fail_count++;
            end
            else
            begin
                want = expected_phases.pop_front();
                if (mode !== want.mode)
                begin
                    $display("%0t mode mismatch: expected %0d actual %0d", $time,
                             want.mode, mode);
                    fail_count++;
                end
                if (smoothed_speed_q8 !== want.speed)
                begin
                    $display("%0t speed mismatch: expected %0d actual %0d", $time,
                             $signed(want.speed), smoothed_speed_q8);
                    fail_count++;
                end
            end
            results_checked++;
            if (!$isunknown(mode))
                mode_hits[mode]++;
        end
    end

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic bit dwell_met(input logic [31:0] now, input logic [31:0] need);
        logic [31:0] spent;
        spent = now - entry_ms;
        return spent >= need;
    endfunction

    function automatic void enter_mode(input logic [1:0] m, input logic [31:0] now);
        cur_mode = m;
        entry_ms = now;
    endfunction

    // Expected mode and smoothed speed for one sample
    function automatic void predict_phase(input logic signed [ALT_W-1:0] alt_in,
                                          input logic [TIME_W-1:0] now);
        longint      alt;
        longint      vz;
        longint      height;
        logic [31:0] dt;
        logic [31:0] held;
        bit          still_f;
        bit          near_f;
        bit          landed;
        alt = alt_in;
        if (prev_ms == 0)
        begin
            // no previous sample: only store it
            prev_ms  = now;
            prev_alt = alt;
            entry_ms = now;
        end
        else
        begin
            dt = now - prev_ms;
            vz = 0;
            height = alt - base_cm;
            if (dt != 0)
            begin
                vz = ((alt - prev_alt) * 1000) / longint'({32'd0, dt});
                if (vz > SPEED_SAT)
                    vz = SPEED_SAT;
                if (vz < -SPEED_SAT)
                    vz = -SPEED_SAT;
            end
            if (mag(vz) < DEADBAND)
                vz = 0;
            avg_q8 = (SMOOTH_ALPHA * vz * 256 + (256 - SMOOTH_ALPHA) * avg_q8) >>> 8;
            still_f = mag(avg_q8) < still_thr * 256;
            near_f  = mag(height) < win_cm;

            case (cur_mode)
                MODE_GROUND:
                begin
                    if (avg_q8 > climb_thr * 256 && dwell_met(now, CLIMB_DWELL))
                        enter_mode(MODE_CLIMB, now);
                end
                MODE_CLIMB:
                begin
                    landed = 1'b0;
                    // hold timer for the return to ground
                    if (still_f && near_f)
                    begin
                        if (hold_ms == 0)
                            hold_ms = now;
                        held = now - hold_ms;
                        if (held >= GROUND_DWELL)
                        begin
                            enter_mode(MODE_GROUND, now);
                            hold_ms = '0;
                            landed = 1'b1;
                        end
                    end
                    else
                        hold_ms = '0;
                    if (!landed && avg_q8 < ff_thr * 256 && dwell_met(now, CLIMB_DWELL))
                        enter_mode(MODE_FREEFALL, now);
                end
                MODE_FREEFALL:
                begin
                    if (avg_q8 > can_in_thr * 256 && height > can_min_cm &&
                        dwell_met(now, FALL_DWELL))
                        enter_mode(MODE_CANOPY, now);
                end
                default:
                begin
                    // back to freefall wins over landing
                    if (avg_q8 < can_out_thr * 256 && dwell_met(now, CANOPY_DWELL))
                        enter_mode(MODE_FREEFALL, now);
                    else if (still_f && near_f && dwell_met(now, GROUND_DWELL))
                        enter_mode(MODE_GROUND, now);
                end
            endcase
            prev_alt = alt;
            prev_ms  = now;
        end
        expected_phases.push_back('{mode: cur_mode, speed: avg_q8[AVG_W-1:0]});
    endfunction

    function automatic logic signed [ALT_W-1:0] clamp_alt(input longint a);
        if (a > ALT_MAX)
            a = ALT_MAX;
        else if (a < ALT_MIN)
            a = ALT_MIN;
        return a[ALT_W-1:0];
    endfunction

    // One sample transaction, with an occasional gap before it
    task automatic send_sample(input logic signed [ALT_W-1:0] alt,
                               input logic [TIME_W-1:0] ms);
        if (in_gaps_on && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        altitude_cm <= alt;
        time_ms     <= ms;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_phase(alt, ms);
        sim_alt = alt;
        sim_ms  = ms;
        samples_sent++;
    endtask

    // Drop valid and let every pending result drain
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_phases.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_GROUND_BASE:  base_cm     = longint'($signed(data[ALT_W-1:0]));
            REG_CLIMB_ENTER:  climb_thr   = longint'($signed(data[SPD_W-1:0]));
            REG_STILL:        still_thr   = longint'(data[STILL_W-1:0]);
            REG_FF_ENTER:     ff_thr      = longint'($signed(data[SPD_W-1:0]));
            REG_CANOPY_ENTER: can_in_thr  = longint'($signed(data[SPD_W-1:0]));
            REG_CANOPY_EXIT:  can_out_thr = longint'($signed(data[SPD_W-1:0]));
            REG_GROUND_WIN:   win_cm      = longint'(data[WIN_W-1:0]);
            default:          can_min_cm  = longint'(data[HGT_W-1:0]);
        endcase
    endtask

    task automatic write_all(input logic [31:0] base, input logic [31:0] climb,
                             input logic [31:0] still, input logic [31:0] ff,
                             input logic [31:0] cin, input logic [31:0] cout,
                             input logic [31:0] win, input logic [31:0] cmin);
        write_reg(REG_GROUND_BASE, base);
        write_reg(REG_CLIMB_ENTER, climb);
        write_reg(REG_STILL, still);
        write_reg(REG_FF_ENTER, ff);
        write_reg(REG_CANOPY_ENTER, cin);
        write_reg(REG_CANOPY_EXIT, cout);
        write_reg(REG_GROUND_WIN, win);
        write_reg(REG_CANOPY_MIN, cmin);
        settings_written++;
    endtask

    // Next sample at a steady climb or sink rate, with a little jitter
    task automatic drift(input int rate, input int per);
        int dt;
        dt = $urandom_range(per * 3 / 4, per * 5 / 4);
        send_sample(clamp_alt(sim_alt + longint'(rate) * dt / 1000 +
                              int'($urandom_range(4)) - 2), sim_ms + dt);
    endtask

    // Random walk with fast moves and the odd repeated timestamp
    task automatic wander(input int n);
        int dt;
        int rate;
        repeat (n)
        begin
            dt   = ($urandom_range(9) == 0) ? 0 : $urandom_range(50, 3000);
            rate = int'($urandom_range(40000)) - 20000;
            send_sample(clamp_alt(sim_alt + longint'(rate) * dt / 1000), sim_ms + dt);
        end
    endtask

    task automatic noise_burst(input int n);
        repeat (n)
        begin
            case ($urandom_range(3))
                0: send_sample(ALT_W'($urandom), $urandom);
                1: send_sample(clamp_alt(sim_alt + int'($urandom_range(200)) - 100), sim_ms);
                2: send_sample(ALT_W'($urandom), '0);
                default: send_sample(ALT_W'($urandom), sim_ms + $urandom_range(1, 100));
            endcase
        end
    endtask

    // Whole jump: ground, climb, freefall, canopy, landing
    task automatic fly_full();
        int     per;
        int     rate;
        int     n;
        longint target;
        per = $urandom_range(300, 1000);
        if ($urandom_range(9) == 0)
            sim_ms = 32'hFFFF_FFFF - $urandom_range(20000);
        sim_alt = base_cm + int'($urandom_range(400)) - 200;
        repeat (3000 / per + 8) drift(0, per);
        rate   = $urandom_range(2000, 5000);
        target = can_min_cm + 25000 + $urandom_range(8000);
        n = 0;
        while (sim_alt - base_cm < target && n < 120)
        begin
            drift(rate, per);
            n++;
        end
        rate = -int'($urandom_range(5000, 8000));
        repeat (2500 / per + 2) drift(rate, per);
        rate = int'(can_in_thr) + int'($urandom_range(100, 500));
        n = 0;
        while (sim_alt - base_cm > win_cm / 4 && n < 150)
        begin
            drift(rate, per);
            n++;
        end
        repeat (6000 / per + 12) drift(0, per);
        flights++;
    endtask

    // Short climb that settles back near the ground
    task automatic hop_and_settle();
        int per;
        int rate;
        int k;
        per  = $urandom_range(200, 800);
        rate = int'(climb_thr) + int'($urandom_range(500, 1500));
        k    = $urandom_range(3, 5);
        repeat (2500 / per + 4) drift(0, per);
        repeat (k) drift(rate, per);
        repeat (k) drift(-rate, per);
        repeat (6000 / per + 14) drift(0, per);
        hops++;
    endtask

    // Field extremes, first sample, zero step, deadband, saturation, wrap
    task automatic test_directed_edges();
        send_sample(21'sd500, 32'd1000);
        send_sample(21'sd500, 32'd1000);
        send_sample(21'sd504, 32'd2000);
        send_sample(21'sd510, 32'd3000);
        send_sample(clamp_alt(ALT_MAX), 32'd3001);
        send_sample(clamp_alt(ALT_MIN), 32'd3002);
        send_sample(21'sd0, 32'd0);
        send_sample(21'sd100, 32'hFFFF_FF00);
        send_sample(21'sd200, 32'h0000_0010);
        send_sample(21'sd300, 32'hFFFF_FFFF);
        send_sample(-21'sd100000, 32'd5);
        send_sample(21'sd1000000, 32'd6);
        send_sample(21'sd999000, 32'd1006);
        send_sample(21'sd999000, 32'd5000);
    endtask

    // Register extremes and odd bit patterns, each followed by a random walk
    task automatic test_register_extremes();
        wait_idle();
        write_all(32'h0010_0000, 32'h0000_4000, 32'h0, 32'h4000, 32'h4000, 32'h4000,
                  32'h0, 32'h0);
        wander(25);
        wait_idle();
        write_all(32'h000F_FFFF, 32'h3FFF, 32'h3FFF, 32'h3FFF, 32'h3FFF, 32'h3FFF,
                  32'h1_FFFF, 32'hF_FFFF);
        wander(25);
        wait_idle();
        write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
        wander(25);
        // permissive: freefall and canopy thresholds near their extremes, canopy exit wins over landing
        wait_idle();
        write_all(32'h0, 32'hFFFF_C000, 32'hFFFF_FFFF, 32'h3FFF, 32'h4000, 32'h3FFF,
                  32'hFFFF_FFFF, 32'h0);
        wander(30);
    endtask

    // Mostly realistic flights under random sane settings, plus noise
    task automatic test_random_flights();
        int start_count;
        int kind;
        start_count   = samples_sent;
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
        while (samples_sent - start_count < RANDOM_ITEMS)
        begin
            if (samples_sent - start_count > QUIET_ITEMS)
            begin
                in_gaps_on    = 1'b1;
                out_stalls_on = 1'b1;
            end
            if (flights + hops == 0 || $urandom_range(3) == 0)
            begin
                wait_idle();
                write_all(32'(int'($urandom_range(250000)) - 50000),
                          32'($urandom_range(50, 500)),
                          32'($urandom_range(20, 200)),
                          32'(-int'($urandom_range(1000, 3000))),
                          32'(-int'($urandom_range(1000, 2000))),
                          32'(-int'($urandom_range(2500, 4500))),
                          32'($urandom_range(1000, 10000)),
                          32'($urandom_range(2000, 10000)));
            end
            kind = $urandom_range(99);
            if (kind < 65)
                fly_full();
            else if (kind < 85)
                hop_and_settle();
            else
                noise_burst($urandom_range(4, 16));
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_register_extremes();
        test_random_flights();

        wait_idle();
        repeat (40) @(posedge clk);
        $display("Sent %0d samples (%0d flights, %0d hops) over %0d register settings;",
                 samples_sent, flights, hops, settings_written);
        $display("checked %0d results: ground %0d climb %0d freefall %0d canopy %0d",
                 results_checked, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
sv/fpd_pkg.sv
sv/flight_phase_detector.sv
verif/tb.sv
